@@ hdl/double_buffer_record_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Double buffer record allocator assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_BUFFER_RECORD_ALLOCATOR_DEFINES_SVH
`define DOUBLE_BUFFER_RECORD_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define DBRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dbra assertion failed");
`define DBRA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dbra reset assertion failed");
`else
`define DBRA_ASSERT(lbl, prop)
`define DBRA_ASSERT_RST(lbl, prop)
`endif

`endif

@@ hdl/dbra_pkg.sv @@
// ----------------------------------------------------------------------------
// Double buffer record allocator package
// Shared widths, codes and record types for the allocator.
// ----------------------------------------------------------------------------
package dbra_pkg;

  localparam int MAX_RECORD_BYTES = 65536;
  localparam int OFFSET_BITS      = 21;
  localparam int SIZE_W           = 21;
  localparam int WRAP_W           = 32;
  localparam int SUM_W            = 34;
  localparam int CFG_IDX_W        = 2;
  localparam int IN_DATA_W        = 56;
  localparam int OUT_DATA_W       = 96;

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_SERVICE    = 2'd1,
    ACT_FORCE_FULL = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_SWITCH   = 3'd1,
    ST_FULL     = 3'd2,
    ST_SERVICED = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER0_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER1_SIZE = 2'd1;

  typedef struct packed {
    action_t             action;
    logic [SIZE_W-1:0]   record_len;
    logic [WRAP_W-1:0]   serviced_wrap;
  } req_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] fill;
    logic [WRAP_W-1:0]      wrap;
    logic [1:0]             flags;
  } state_t;

  typedef struct packed {
    status_t             status;
    logic                buffer_select;
    logic [SIZE_W-1:0]   start_offset;
    logic [WRAP_W-1:0]   prev_wrap;
    logic [SIZE_W-1:0]   prev_offset;
    logic [SIZE_W-1:0]   bytes_allocated;
  } res_t;

endpackage

@@ hdl/dbra_step.sv @@
// ----------------------------------------------------------------------------
// Double buffer record allocator step
// One atomic allocator step: next state and result for one request.
// ----------------------------------------------------------------------------
module dbra_step (
  input  dbra_pkg::req_t                  req,
  input  dbra_pkg::state_t                st,
  input  logic [dbra_pkg::SIZE_W-1:0]     buf0_size,
  input  logic [dbra_pkg::SIZE_W-1:0]     buf1_size,
  output dbra_pkg::state_t                st_nxt,
  output dbra_pkg::res_t                  res
);
  import dbra_pkg::*;

  logic              cur;
  logic              nxt;
  logic [SIZE_W-1:0] cur_size;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    cur      = st.wrap[0];
    nxt      = ~cur;
    cur_size = cur ? buf1_size : buf0_size;
    sum      = SUM_W'(st.fill) + SUM_W'(req.record_len);
    st_nxt   = st;
    res      = '0;
    res.status = ST_DONE;
    case (req.action)
      ACT_ALLOC: begin
        if (req.record_len > SIZE_W'(MAX_RECORD_BYTES)) begin
          res.status = ST_FULL;
        end else if (sum > SUM_W'(cur_size)) begin
          if (st.flags[nxt] || (buf1_size == '0)) begin
            res.status = ST_FULL;
          end else begin
            res.prev_wrap     = st.wrap;
            res.prev_offset   = SIZE_W'(st.fill);
            st_nxt.flags[cur] = 1'b1;
            st_nxt.wrap       = st.wrap + WRAP_W'(1);
            st_nxt.fill       = OFFSET_BITS'(req.record_len);
            res.status        = ST_SWITCH;
            res.buffer_select = nxt;
          end
        end else begin
          res.start_offset  = SIZE_W'(st.fill);
          st_nxt.fill       = OFFSET_BITS'(sum);
          res.status        = ST_ALLOC;
          res.buffer_select = cur;
        end
      end
      ACT_SERVICE: begin
        if ((st.wrap == (req.serviced_wrap + WRAP_W'(1))) &&
            st.flags[req.serviced_wrap[0]]) begin
          st_nxt.flags[req.serviced_wrap[0]] = 1'b0;
          res.status = ST_SERVICED;
        end else begin
          res.status = ST_REFUSED;
        end
      end
      ACT_FORCE_FULL: begin
        st_nxt.flags[nxt] = 1'b1;
        st_nxt.fill       = OFFSET_BITS'(cur_size);
      end
      ACT_CLEAR: begin
        st_nxt = '0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.bytes_allocated = SIZE_W'(st_nxt.fill);
  end

endmodule

@@ hdl/double_buffer_record_allocator.sv @@
// ----------------------------------------------------------------------------
// Double buffer record allocator
// Bump allocator over two trace buffers with wrap count and filled flags.
// ----------------------------------------------------------------------------
// One request is accepted every cycle unless the result is stalled. Each
// request is held in the input register, then captured in the result
// register, which drives out_tvalid. The allocator state is updated as a
// request moves from the input register into the result register, so
// consecutive requests see each other's effects with no gap. A stalled
// result holds the pipeline; the input side keeps taking a transfer as
// long as the input register can advance. Buffer sizes are to be written
// through the cfg port while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
`include "double_buffer_record_allocator_defines.svh"

module double_buffer_record_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [dbra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbra_pkg::SIZE_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // record_len[20:0], serviced_wrap[52:21], zero pad
  input  logic [dbra_pkg::IN_DATA_W-1:0]      in_tdata,
  // action[1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // buffer_select[0], start_offset[21:1], prev_wrap[53:22],
  // prev_offset[74:54], bytes_allocated[95:75]
  output logic [dbra_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[2:0]
  output logic [2:0]                          out_tuser
);
  import dbra_pkg::*;

  logic [SIZE_W-1:0] buf0_size_r;
  logic [SIZE_W-1:0] buf1_size_r;
  logic              s1_v_r;
  req_t              s1_req_r;
  state_t            st_r;
  state_t            st_nxt;
  logic              out_v_r;
  res_t              res_r;
  res_t              res_nxt;
  logic              advance;
  req_t              in_req;

  assign in_req.action        = action_t'(in_tuser);
  assign in_req.record_len    = in_tdata[SIZE_W-1:0];
  assign in_req.serviced_wrap = in_tdata[SIZE_W+WRAP_W-1:SIZE_W];

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  dbra_step u_step (
    .req       (s1_req_r),
    .st        (st_r),
    .buf0_size (buf0_size_r),
    .buf1_size (buf1_size_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf0_size_r <= '0;
      buf1_size_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BUFFER0_SIZE: buf0_size_r <= cfg_wdata;
          CFG_BUFFER1_SIZE: buf1_size_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.bytes_allocated, res_r.prev_offset, res_r.prev_wrap,
                       res_r.start_offset, res_r.buffer_select};

  `DBRA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid)
  `DBRA_ASSERT(a_take_when_free, (!out_tvalid || out_tready) |-> in_tready)
  `DBRA_ASSERT(a_no_grant_zero,
    (out_tvalid && (res_r.status != ST_ALLOC) && (res_r.status != ST_SWITCH)) |->
    (!res_r.buffer_select && (res_r.start_offset == '0)))
  `DBRA_ASSERT(a_alloc_grows,
    (out_tvalid && (res_r.status == ST_ALLOC)) |->
    (res_r.bytes_allocated >= res_r.start_offset))

endmodule

@@ test/double_buffer_record_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// Double buffer record allocator checker
// Tracks buffer sizes from the cfg port, predicts the outcome of every
// accepted request from its own copy of the fill offset, wrap count and
// filled flags, and compares each result transfer field by field against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module double_buffer_record_allocator_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [dbra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbra_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // record_len[20:0], serviced_wrap[52:21], zero pad
  input  logic [dbra_pkg::IN_DATA_W-1:0]    in_tdata,
  // action[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // buffer_select[0], start_offset[21:1], prev_wrap[53:22],
  // prev_offset[74:54], bytes_allocated[95:75]
  input  logic [dbra_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  input  logic [2:0]                        out_tuser,
  output int                                mismatches,
  output int                                pending,
  output int                                outcomes_checked,
  output int                                switches_seen
);
  import dbra_pkg::*;

  logic [SIZE_W-1:0]      size0 = '0;
  logic [SIZE_W-1:0]      size1 = '0;
  logic [OFFSET_BITS-1:0] fill  = '0;
  logic [WRAP_W-1:0]      wrap  = '0;
  logic [1:0]             flags = '0;
  res_t                   outcomes_q[$];
  int                     fail_count   = 0;
  int                     check_count  = 0;
  int                     switch_count = 0;
  int                     pend_count   = 0;

  assign mismatches       = fail_count;
  assign pending          = pend_count;
  assign outcomes_checked = check_count;
  assign switches_seen    = switch_count;

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  function automatic res_t apply_request(action_t act, logic [SIZE_W-1:0] nb,
                                         logic [WRAP_W-1:0] sw);
    res_t              r;
    logic              cur;
    logic [SIZE_W-1:0] cur_size;
    r = '0;
    r.status = ST_DONE;
    cur = wrap[0];
    cur_size = cur ? size1 : size0;
    case (act)
      ACT_ALLOC: begin
        if (nb > SIZE_W'(MAX_RECORD_BYTES)) begin
          r.status = ST_FULL;
        end else if ({1'b0, fill} + {1'b0, nb} > {1'b0, cur_size}) begin
          if (flags[~cur] || size1 == '0) begin
            r.status = ST_FULL;
          end else begin
            r.status        = ST_SWITCH;
            r.buffer_select = ~cur;
            r.prev_wrap     = wrap;
            r.prev_offset   = fill;
            flags[cur]      = 1'b1;
            wrap            = wrap + 32'd1;
            fill            = nb;
          end
        end else begin
          r.status        = ST_ALLOC;
          r.buffer_select = cur;
          r.start_offset  = fill;
          fill            = fill + nb;
        end
      end
      ACT_SERVICE: begin
        if (wrap == sw + 32'd1 && flags[sw[0]]) begin
          flags[sw[0]] = 1'b0;
          r.status = ST_SERVICED;
        end else begin
          r.status = ST_REFUSED;
        end
      end
      ACT_FORCE_FULL: begin
        flags[~cur] = 1'b1;
        fill = cur_size;
      end
      default: begin
        fill  = '0;
        wrap  = '0;
        flags = '0;
      end
    endcase
    r.bytes_allocated = fill;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      size0 = '0;
      size1 = '0;
      fill  = '0;
      wrap  = '0;
      flags = '0;
      outcomes_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status          = status_t'(out_tuser);
        got.buffer_select   = out_tdata[0];
        got.start_offset    = out_tdata[21:1];
        got.prev_wrap       = out_tdata[53:22];
        got.prev_offset     = out_tdata[74:54];
        got.bytes_allocated = out_tdata[95:75];
        if (outcomes_q.size() == 0) begin
          flag_mismatch("result with nothing pending", out_tuser, 0);
        end else begin
          want = outcomes_q.pop_front();
          check_count++;
          if (want.status == ST_SWITCH) switch_count++;
          if (got.status !== want.status)
            flag_mismatch("status code", got.status, want.status);
          if (got.buffer_select !== want.buffer_select)
            flag_mismatch("buffer_select", got.buffer_select, want.buffer_select);
          if (got.start_offset !== want.start_offset)
            flag_mismatch("start_offset", got.start_offset, want.start_offset);
          if (got.prev_wrap !== want.prev_wrap)
            flag_mismatch("prev_wrap", got.prev_wrap, want.prev_wrap);
          if (got.prev_offset !== want.prev_offset)
            flag_mismatch("prev_offset", got.prev_offset, want.prev_offset);
          if (got.bytes_allocated !== want.bytes_allocated)
            flag_mismatch("bytes_allocated", got.bytes_allocated, want.bytes_allocated);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BUFFER0_SIZE: size0 = cfg_wdata;
          CFG_BUFFER1_SIZE: size1 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        outcomes_q.push_back(apply_request(action_t'(in_tuser), in_tdata[20:0],
                                           in_tdata[52:21]));
      end
    end
    pend_count = outcomes_q.size();
  end

endmodule

@@ test/double_buffer_record_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// Double buffer record allocator testbench
// Drives a directed sequence through allocation, switch, full, service,
// force-full and clear cases, then random request mixes under a range of
// buffer sizes with random idle cycles on both streams. The checker beside
// the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module double_buffer_record_allocator_tb;
  import dbra_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int                   NUM_PHASES    = 8;
  localparam int                   PHASE_ITEMS   = 105;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [SIZE_W-1:0]      cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic [1:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [2:0]             out_tuser;

  int                     mismatches;
  int                     pending;
  int                     outcomes_checked;
  int                     switches_seen;
  logic                   quiet         = 1'b0;
  logic [WRAP_W-1:0]      seen_wrap     = '0;
  int                     requests_sent = 0;
  int                     size_settings = 0;

  double_buffer_record_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  double_buffer_record_allocator_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatches       (mismatches),
    .pending          (pending),
    .outcomes_checked (outcomes_checked),
    .switches_seen    (switches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= (!rst_n || quiet) ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  // track the wrap count seen on switch results to aim service requests
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && status_t'(out_tuser) == ST_SWITCH)
      seen_wrap <= out_tdata[53:22] + 32'd1;
  end

  task automatic send_req(action_t act, logic [SIZE_W-1:0] nb, logic [WRAP_W-1:0] sw);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, sw, nb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic resize_buffers(logic [SIZE_W-1:0] b0, logic [SIZE_W-1:0] b1);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BUFFER0_SIZE;
    cfg_wdata <= b0;
    @(posedge clk);
    cfg_index <= CFG_BUFFER1_SIZE;
    cfg_wdata <= b1;
    @(posedge clk);
    cfg_index <= CFG_SPARE_IDX;
    cfg_wdata <= SIZE_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_settings++;
  endtask

  task automatic issue_random(int unsigned span);
    int unsigned       pick;
    action_t           act;
    logic [SIZE_W-1:0] nb;
    logic [WRAP_W-1:0] sw;
    pick = $urandom_range(0, 99);
    nb   = SIZE_W'($urandom_range(0, 1048576));
    sw   = $urandom;
    act  = ACT_ALLOC;
    if (pick < 58) begin
      nb = SIZE_W'(8 * $urandom_range(0, span / 8));
    end else if (pick < 66) begin
      nb = SIZE_W'($urandom_range(0, span));
    end else if (pick < 70) begin
      nb = SIZE_W'($urandom_range(MAX_RECORD_BYTES - 8, 1048576));
    end else if (pick < 92) begin
      act = ACT_SERVICE;
      if (pick < 87) sw = seen_wrap - 32'd1;
      else if (pick < 90) sw = seen_wrap - 32'd2;
    end else if (pick < 97) begin
      act = ACT_FORCE_FULL;
    end else begin
      act = ACT_CLEAR;
    end
    send_req(act, nb, sw);
  endtask

  initial begin
    logic [SIZE_W-1:0] b0;
    logic [SIZE_W-1:0] b1;
    int unsigned       span;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: both buffers empty, one-shot
    send_req(ACT_ALLOC, 21'd0, 32'd0);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    resize_buffers(21'd256, 21'd128);
    send_req(ACT_ALLOC, 21'd1048576, 32'd0);
    send_req(ACT_ALLOC, 21'd65537, 32'd0);
    send_req(ACT_ALLOC, 21'd65536, 32'd0);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    send_req(ACT_SERVICE, 21'd0, 32'd0);
    send_req(ACT_SERVICE, 21'd0, 32'd0);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    send_req(ACT_ALLOC, 21'd13, 32'd0);
    send_req(ACT_ALLOC, 21'd235, 32'd0);
    send_req(ACT_ALLOC, 21'd0, 32'd0);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    send_req(ACT_SERVICE, 21'd0, 32'd1);
    send_req(ACT_FORCE_FULL, 21'h1FFFFF, 32'hFFFFFFFF);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    send_req(ACT_SERVICE, 21'd0, 32'd1);
    send_req(ACT_ALLOC, 21'd8, 32'd0);
    send_req(ACT_FORCE_FULL, 21'd0, 32'd0);
    send_req(ACT_ALLOC, 21'd0, 32'd0);
    send_req(ACT_CLEAR, 21'd1048576, 32'hFFFFFFFF);
    send_req(ACT_FORCE_FULL, 21'd0, 32'd0);
    send_req(ACT_SERVICE, 21'd0, 32'hFFFFFFFF);
    send_req(ACT_SERVICE, 21'd0, 32'h5A5A5A5A);
    send_req(ACT_CLEAR, 21'd0, 32'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin b0 = 21'd1048576; b1 = 21'd1048576; end
        1: begin b0 = 21'd256;     b1 = 21'd128;     end
        2: begin b0 = 21'd64;      b1 = 21'd0;       end
        3: begin b0 = 21'd0;       b1 = 21'd0;       end
        4: begin b0 = 21'd4096;    b1 = 21'd16;      end
        5: begin b0 = 21'd0;       b1 = 21'd512;     end
        6: begin b0 = 21'd65536;   b1 = 21'd65536;   end
        default: begin b0 = 21'd1000; b1 = 21'd1048576; end
      endcase
      resize_buffers(b0, b1);
      span = 32'((b0 > b1) ? b0 : b1);
      span = span / 3;
      if (span > MAX_RECORD_BYTES) span = MAX_RECORD_BYTES;
      if (span < 16) span = 16;
      quiet <= (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!quiet && $urandom_range(0, 99) < 7) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        issue_random(span);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    $display("covered %0d requests over %0d buffer size settings", requests_sent,
             size_settings);
    $display("checked %0d results, %0d of them buffer switches", outcomes_checked,
             switches_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dbra_pkg.sv
hdl/dbra_step.sv
hdl/double_buffer_record_allocator.sv
test/double_buffer_record_allocator_checker.sv
test/double_buffer_record_allocator_tb.sv
